### src/hrt_pkg.sv
`default_nettype none

package hrt_pkg;

  // Character codes that terminate tokens.
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChNl    = 8'h0A;

  // Parse phases.
  localparam logic [3:0] PhMethod   = 4'd0;
  localparam logic [3:0] PhUrlSkip  = 4'd1;
  localparam logic [3:0] PhUrl      = 4'd2;
  localparam logic [3:0] PhVerSkip  = 4'd3;
  localparam logic [3:0] PhVer      = 4'd4;
  localparam logic [3:0] PhLine     = 4'd5;
  localparam logic [3:0] PhName     = 4'd6;
  localparam logic [3:0] PhNameSkip = 4'd7;
  localparam logic [3:0] PhValue    = 4'd8;
  localparam logic [3:0] PhDone     = 4'd9;

  // Event kinds.
  localparam logic [1:0] EvByte = 2'd0;
  localparam logic [1:0] EvEnd  = 2'd1;
  localparam logic [1:0] EvFin  = 2'd2;

  // Field kinds.
  localparam logic [2:0] FkMethod = 3'd0;
  localparam logic [2:0] FkUrl    = 3'd1;
  localparam logic [2:0] FkVer    = 3'd2;
  localparam logic [2:0] FkName   = 3'd3;
  localparam logic [2:0] FkValue  = 3'd4;

  // Most results one byte can cause.
  localparam logic [1:0] MaxRes = 2'd3;

  typedef struct packed {
    logic [3:0] phase;
    logic [7:0] held;
    logic       held_v;
    logic [1:0] lsc;
  } tok_state_t;

  typedef struct packed {
    logic [1:0] ev;
    logic [2:0] fk;
    logic [7:0] pb;
  } tok_res_t;

  typedef struct packed {
    tok_res_t [2:0] res;
    logic [1:0]     cnt;
  } tok_bundle_t;

  typedef struct packed {
    tok_state_t  st;
    tok_bundle_t bd;
  } tok_ctx_t;

  localparam tok_state_t StReset = '{phase: PhMethod, held: 8'd0, held_v: 1'b0, lsc: 2'd0};

  // Appends one result to the bundle; results beyond the limit are dropped.
  function automatic tok_ctx_t emit(tok_ctx_t c, logic [1:0] ev, logic [2:0] fk,
                                    logic [7:0] pb);
    tok_ctx_t r;
    r = c;
    if (c.bd.cnt != MaxRes) begin
      r.bd.res[c.bd.cnt].ev = ev;
      r.bd.res[c.bd.cnt].fk = fk;
      r.bd.res[c.bd.cnt].pb = pb;
      r.bd.cnt = c.bd.cnt + 2'd1;
    end
    return r;
  endfunction

  // Runs one byte through every phase except the start of a header line.
  function automatic tok_ctx_t feed(tok_ctx_t c, logic [7:0] b);
    tok_ctx_t r;
    logic     skip;
    r = c;
    skip = 1'b0;
    // Space-skipping phases either swallow the byte or open the next token.
    case (r.st.phase)
      PhUrlSkip: begin
        if (b == ChSpace) skip = 1'b1;
        else r.st.phase = PhUrl;
      end
      PhVerSkip: begin
        if (b == ChSpace) skip = 1'b1;
        else r.st.phase = PhVer;
      end
      PhNameSkip: begin
        if (b == ChSpace) skip = 1'b1;
        else begin
          r.st.phase = PhValue;
          r.st.held_v = 1'b0;
        end
      end
      default: ;
    endcase
    if (!skip) begin
      case (r.st.phase)
        PhMethod: begin
          if (b == ChSpace) begin
            r = emit(r, EvEnd, FkMethod, 8'd0);
            r.st.phase = PhUrlSkip;
          end else r = emit(r, EvByte, FkMethod, b);
        end
        PhUrl: begin
          if (b == ChSpace) begin
            r = emit(r, EvEnd, FkUrl, 8'd0);
            r.st.phase = PhVerSkip;
          end else r = emit(r, EvByte, FkUrl, b);
        end
        PhVer: begin
          if (b == ChNl) begin
            r = emit(r, EvEnd, FkVer, 8'd0);
            r.st.phase = PhLine;
            r.st.lsc = 2'd0;
          end else r = emit(r, EvByte, FkVer, b);
        end
        PhName: begin
          if (b == ChColon || b == ChNl || b == ChSpace) begin
            r = emit(r, EvEnd, FkName, 8'd0);
            r.st.phase = PhNameSkip;
          end else r = emit(r, EvByte, FkName, b);
        end
        PhValue: begin
          if (b == ChNl) begin
            r.st.held_v = 1'b0;
            r = emit(r, EvEnd, FkValue, 8'd0);
            r.st.phase = PhLine;
            r.st.lsc = 2'd0;
          end else begin
            // One-byte holdback drops the byte before the newline.
            if (r.st.held_v) r = emit(r, EvByte, FkValue, r.st.held);
            r.st.held = b;
            r.st.held_v = 1'b1;
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/hrt_step.sv
`default_nettype none

module hrt_step
  import hrt_pkg::*;
(
  input  tok_state_t  st_i,
  input  logic [7:0]  req_byte_i,
  input  logic        req_last_i,
  output tok_state_t  st_nxt_o,
  output tok_bundle_t bd_o
);

  tok_ctx_t c;

  // Next parse state and the results of one byte.
  always_comb begin
    c.st = st_i;
    c.bd = '0;
    if (st_i.phase == PhLine) begin
      // Header line start: a newline in the first two bytes ends the headers.
      if (req_byte_i == ChNl) begin
        c.st.phase = PhDone;
        c.st.lsc = 2'd0;
      end else if (st_i.lsc == 2'd0) begin
        if (!req_last_i) begin
          c.st.held = req_byte_i;
          c.st.held_v = 1'b0;
          c.st.lsc = 2'd1;
        end
      end else begin
        c.st.lsc = 2'd0;
        if (!req_last_i) begin
          c.st.phase = PhName;
          c = feed(c, st_i.held);
          c = feed(c, req_byte_i);
        end
      end
    end else if (st_i.phase <= PhValue) begin
      c = feed(c, req_byte_i);
    end

    // The last byte closes any open token and finishes the request.
    if (req_last_i) begin
      case (c.st.phase)
        PhMethod: c = emit(c, EvEnd, FkMethod, 8'd0);
        PhUrl:    c = emit(c, EvEnd, FkUrl, 8'd0);
        PhVer:    c = emit(c, EvEnd, FkVer, 8'd0);
        PhName:   c = emit(c, EvEnd, FkName, 8'd0);
        PhValue:  c = emit(c, EvEnd, FkValue, 8'd0);
        default: ;
      endcase
      c = emit(c, EvFin, FkMethod, 8'd0);
      c.st = StReset;
    end
  end

  assign st_nxt_o = c.st;
  assign bd_o = c.bd;

endmodule

`default_nettype wire

### src/hrt_obuf.sv
`default_nettype none

module hrt_obuf
  import hrt_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         load_i,
  input  tok_bundle_t load_bd_i,
  output logic        free_o,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_event_kind,
  output logic [2:0]  out_field_kind,
  output logic [7:0]  out_payload_byte,
  output logic        out_final_result
);

  tok_bundle_t bd_r;
  logic        valid_r, valid_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        out_fire, at_end;

  assign out_fire = valid_r && !out_stall;
  assign at_end   = (pos_r == bd_r.cnt - 2'd1);

  // The buffer can take a new bundle when empty or when its last result leaves now.
  assign free_o = !valid_r || (out_fire && at_end);

  // Sequence through the stored results one transaction at a time.
  always_comb begin
    valid_nxt = valid_r;
    pos_nxt = pos_r;
    if (out_fire) begin
      if (at_end) valid_nxt = 1'b0;
      else pos_nxt = pos_r + 2'd1;
    end
    if (load_i) begin
      valid_nxt = 1'b1;
      pos_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) bd_r <= load_bd_i;
  end

  assign out_valid        = valid_r;
  assign out_event_kind   = bd_r.res[pos_r].ev;
  assign out_field_kind   = bd_r.res[pos_r].fk;
  assign out_payload_byte = bd_r.res[pos_r].pb;
  assign out_final_result = at_end;

endmodule

`default_nettype wire

### src/http_request_tokenizer_core.sv
// Streaming tokenizer for the head of an HTTP request. Bytes enter one per
// transaction and leave as labeled results: payload bytes tagged method, URL,
// version, header name or header value, token-end events at terminators, and
// a request-finished event after the byte marked last. A byte that causes at
// most one result is taken every cycle while the output is not stalled; a
// byte that causes n results (n up to three) holds the result buffer until
// all n have left, since the output moves one result per transaction. A new
// byte is taken in the same cycle that the final result of the previous byte
// leaves. The last byte before a header value's newline is dropped, CR or not.

`default_nettype none

module http_request_tokenizer_core
  import hrt_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [7:0]  in_req_byte,
  input  wire        in_req_last,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [1:0] out_event_kind,
  output logic [2:0] out_field_kind,
  output logic [7:0] out_payload_byte,
  output logic       out_final_result
);

  tok_state_t  st_r, st_nxt;
  tok_bundle_t bd;
  logic        free, in_fire;

  hrt_step u_step (
    .st_i       (st_r),
    .req_byte_i (in_req_byte),
    .req_last_i (in_req_last),
    .st_nxt_o   (st_nxt),
    .bd_o       (bd)
  );

  assign in_stall = !free;
  assign in_fire  = in_valid && free;

  // Parse state advances on every accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StReset;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  hrt_obuf u_obuf (
    .clk              (clk),
    .rst_n            (rst_n),
    .load_i           (in_fire && (bd.cnt != 2'd0)),
    .load_bd_i        (bd),
    .free_o           (free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_field_kind   (out_field_kind),
    .out_payload_byte (out_payload_byte),
    .out_final_result (out_final_result)
  );

endmodule

`default_nettype wire

### tb/sv/http_request_tokenizer_core_tb.sv
import hrt_pkg::*;

// One labeled event as it leaves the tokenizer.
typedef struct packed {
  logic [1:0] ev;
  logic [2:0] fk;
  logic [7:0] pb;
  logic       fin;
} token_event_t;

// Tracks the parse of the request stream and checks every event the block emits.
class token_scoreboard;
  localparam logic [2:0] NoField = 3'd0;

  logic [3:0]   phase;
  logic [7:0]   held_byte;
  logic         held_ok;
  logic [1:0]   line_bytes;
  token_event_t step_events[$];
  token_event_t expected_events[$];
  int           mismatches;
  int           parsed_bytes;
  int           checked_events;

  function new();
    mismatches = 0;
    parsed_bytes = 0;
    checked_events = 0;
    clear_parse();
  endfunction

  function void clear_parse();
    phase = PhMethod;
    held_byte = 8'd0;
    held_ok = 1'b0;
    line_bytes = 2'd0;
  endfunction

  // At most three events come out of one byte; further ones are dropped.
  function void push_step_event(logic [1:0] ev, logic [2:0] fk, logic [7:0] pb);
    token_event_t e;
    if (step_events.size() >= int'(MaxRes)) return;
    e.ev = ev;
    e.fk = fk;
    e.pb = pb;
    e.fin = 1'b0;
    step_events.push_back(e);
  endfunction

  // Labels one byte in every phase except the start of a header line.
  function void label_byte(logic [7:0] b);
    // Space runs after a token are swallowed; anything else opens the next token.
    case (phase)
      PhUrlSkip: begin
        if (b == ChSpace) return;
        phase = PhUrl;
      end
      PhVerSkip: begin
        if (b == ChSpace) return;
        phase = PhVer;
      end
      PhNameSkip: begin
        if (b == ChSpace) return;
        phase = PhValue;
        held_ok = 1'b0;
      end
      default: ;
    endcase
    case (phase)
      PhMethod: begin
        if (b == ChSpace) begin
          push_step_event(EvEnd, FkMethod, 8'd0);
          phase = PhUrlSkip;
        end else begin
          push_step_event(EvByte, FkMethod, b);
        end
      end
      PhUrl: begin
        if (b == ChSpace) begin
          push_step_event(EvEnd, FkUrl, 8'd0);
          phase = PhVerSkip;
        end else begin
          push_step_event(EvByte, FkUrl, b);
        end
      end
      PhVer: begin
        if (b == ChNl) begin
          push_step_event(EvEnd, FkVer, 8'd0);
          phase = PhLine;
          line_bytes = 2'd0;
        end else begin
          push_step_event(EvByte, FkVer, b);
        end
      end
      PhName: begin
        if (b == ChColon || b == ChNl || b == ChSpace) begin
          push_step_event(EvEnd, FkName, 8'd0);
          phase = PhNameSkip;
        end else begin
          push_step_event(EvByte, FkName, b);
        end
      end
      PhValue: begin
        if (b == ChNl) begin
          held_ok = 1'b0;
          push_step_event(EvEnd, FkValue, 8'd0);
          phase = PhLine;
          line_bytes = 2'd0;
        end else begin
          // The byte right before the newline never leaves the holdback.
          if (held_ok) push_step_event(EvByte, FkValue, held_byte);
          held_byte = b;
          held_ok = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // Called for every accepted input transaction.
  function void note_request_byte(logic [7:0] b, logic last);
    logic [7:0] first;
    step_events.delete();
    if (phase != PhDone || last) parsed_bytes++;
    // A header line is judged on its first two bytes before it is labeled.
    if (phase == PhLine) begin
      if (b == ChNl) begin
        phase = PhDone;
        line_bytes = 2'd0;
      end else if (line_bytes == 2'd0) begin
        if (!last) begin
          held_byte = b;
          held_ok = 1'b0;
          line_bytes = 2'd1;
        end
      end else begin
        line_bytes = 2'd0;
        if (!last) begin
          first = held_byte;
          phase = PhName;
          label_byte(first);
          label_byte(b);
        end
      end
    end else if (phase <= PhValue) begin
      label_byte(b);
    end
    // The last byte closes any open token and finishes the request.
    if (last) begin
      case (phase)
        PhMethod: push_step_event(EvEnd, FkMethod, 8'd0);
        PhUrl:    push_step_event(EvEnd, FkUrl, 8'd0);
        PhVer:    push_step_event(EvEnd, FkVer, 8'd0);
        PhName:   push_step_event(EvEnd, FkName, 8'd0);
        PhValue: begin
          held_ok = 1'b0;
          push_step_event(EvEnd, FkValue, 8'd0);
        end
        default: ;
      endcase
      push_step_event(EvFin, NoField, 8'd0);
      clear_parse();
    end
    if (step_events.size() > 0) step_events[step_events.size() - 1].fin = 1'b1;
    foreach (step_events[i]) expected_events.push_back(step_events[i]);
  endfunction

  task report_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Called for every accepted result transaction.
  task check_token_event(logic [1:0] ev, logic [2:0] fk, logic [7:0] pb, logic fin);
    token_event_t want;
    checked_events++;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("unexpected event ev=%0d fk=%0d pb=%02h fin=%0b",
                                ev, fk, pb, fin));
      return;
    end
    want = expected_events.pop_front();
    if (ev !== want.ev)
      report_mismatch($sformatf("event kind %0d, expected %0d", ev, want.ev));
    if (fk !== want.fk)
      report_mismatch($sformatf("field kind %0d, expected %0d", fk, want.fk));
    if (pb !== want.pb)
      report_mismatch($sformatf("payload byte %02h, expected %02h", pb, want.pb));
    if (fin !== want.fin)
      report_mismatch($sformatf("final flag %0b, expected %0b", fin, want.fin));
  endtask

  function int pending();
    return expected_events.size();
  endfunction

  // Anything still queued at the end never came out of the block.
  task close_out();
    if (expected_events.size() > 0) begin
      report_mismatch($sformatf("%0d expected events never arrived",
                                expected_events.size()));
      mismatches += expected_events.size() - 1;
    end
  endtask
endclass

module http_request_tokenizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_req_byte;
  logic       in_req_last;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_event_kind;
  logic [2:0] out_field_kind;
  logic [7:0] out_payload_byte;
  logic       out_final_result;

  token_scoreboard sb;
  logic [7:0]      req_bytes[$];
  int              burst_left;
  bit              steady;
  int              requests_sent;

  http_request_tokenizer_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_byte     (in_req_byte),
    .in_req_last     (in_req_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_field_kind  (out_field_kind),
    .out_payload_byte(out_payload_byte),
    .out_final_result(out_final_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run must never get this far.
  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // The receiver switches among four stall patterns: none, light or heavy random, and periodic.
  initial begin
    int stall_mode;
    int cycle_count;
    stall_mode = 0;
    cycle_count = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      cycle_count++;
      if (cycle_count % 48 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: out_stall <= (cycle_count % 7 >= 4);
        3: out_stall <= ($urandom_range(0, 2) != 0);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // Both channels are sampled at the rising edge; inputs are noted before results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request_byte(in_req_byte, in_req_last);
      if (out_valid && !out_stall)
        sb.check_token_event(out_event_kind, out_field_kind, out_payload_byte,
                             out_final_result);
    end
  end

  // Presents one byte at the falling edge and holds it until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req_byte <= b;
    in_req_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit last_at_end);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], last_at_end && (i == s.len() - 1));
  endtask

  task automatic send_request();
    foreach (req_bytes[i]) send_byte(req_bytes[i], i == req_bytes.size() - 1);
    requests_sent++;
  endtask

  // A byte that terminates nothing in a method, URL, version or header name.
  function automatic logic [7:0] token_char();
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 1) == 0) b = 8'($urandom_range(8'h61, 8'h7A));
      else b = 8'($urandom_range(0, 255));
    end while (b == ChSpace || b == ChColon || b == ChNl);
    return b;
  endfunction

  function automatic logic [7:0] value_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == ChNl);
    return b;
  endfunction

  // Bytes heavy in terminators, for malformed requests.
  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 7))
      0: return ChSpace;
      1: return ChColon;
      2: return ChNl;
      3: return 8'h0D;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed requests with random content; some noise and truncation.
  function automatic void build_request();
    int cut;
    int name_end;
    req_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) req_bytes.push_back(noise_char());
      return;
    end
    repeat ($urandom_range(0, 5)) req_bytes.push_back(token_char());
    repeat ($urandom_range(1, 3)) req_bytes.push_back(ChSpace);
    repeat ($urandom_range(0, 6)) req_bytes.push_back(token_char());
    repeat ($urandom_range(1, 2)) req_bytes.push_back(ChSpace);
    repeat ($urandom_range(0, 4)) req_bytes.push_back(token_char());
    if ($urandom_range(0, 3) != 0) req_bytes.push_back(8'h0D);
    req_bytes.push_back(ChNl);
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(1, 5)) req_bytes.push_back(token_char());
      name_end = $urandom_range(0, 9);
      if (name_end < 7) req_bytes.push_back(ChColon);
      else if (name_end < 9) req_bytes.push_back(ChSpace);
      else req_bytes.push_back(ChNl);
      repeat ($urandom_range(0, 2)) req_bytes.push_back(ChSpace);
      repeat ($urandom_range(0, 6)) req_bytes.push_back(value_char());
      if ($urandom_range(0, 4) != 0) req_bytes.push_back(8'h0D);
      req_bytes.push_back(ChNl);
    end
    if ($urandom_range(0, 2) != 0) req_bytes.push_back(8'h0D);
    req_bytes.push_back(ChNl);
    repeat ($urandom_range(0, 3)) req_bytes.push_back(8'($urandom_range(0, 255)));
    // Cut the request short at a random point.
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, req_bytes.size());
      while (req_bytes.size() > cut) void'(req_bytes.pop_back());
    end
  endfunction

  initial begin
    int drain;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_byte = 8'd0;
    in_req_last = 1'b0;
    burst_left = 0;
    steady = 1'b0;
    requests_sent = 0;
    sb = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every phase, a carriage return dropped from a value, the end of
    // the headers, ignored trailing bytes and a last byte after the headers.
    send_text("M  u V\nk: x", 1'b0);
    send_byte(8'h0D, 1'b0);
    send_text("\n\nz", 1'b0);
    send_byte("q", 1'b1);
    // A lone last byte that opens and closes the method.
    send_byte(8'hFF, 1'b1);
    // An empty method closed by the last byte.
    send_byte(ChSpace, 1'b1);
    // A zero byte in the version, a name ended by newline, a value cut by the last byte.
    send_text("a b ", 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("\nhh\nv", 1'b0);
    send_byte("w", 1'b1);
    // A header line truncated after its first byte.
    send_text("G / H\nx", 1'b1);

    // Random requests; some with the sender never pausing.
    while (sb.parsed_bytes < 120) begin
      steady = ($urandom_range(0, 3) == 0);
      build_request();
      send_request();
    end
    in_valid <= 1'b0;

    drain = 0;
    while (sb.pending() > 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    sb.close_out();
    $display("Sent %0d random requests plus directed cases:", requests_sent);
    $display("%0d bytes parsed, %0d events checked.", sb.parsed_bytes,
             sb.checked_events);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
